### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; macros compile to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/bub_pkg.sv
// shared types, codes and helpers of the bilinear upscaler
// no dependencies
`default_nettype none

package bub_pkg;

  localparam int IDX_W     = 5;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int STORE_DIM = 32;
  localparam int POS_W     = 2 * IDX_W;
  localparam int LERP_W    = 2 * PIX_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ROWS = 1'b0,
    CFG_SRC_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic             out_of_range;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CN,
    ST_CQ,
    ST_CR,
    ST_RN,
    ST_RQ,
    ST_RR,
    ST_RF,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_H0B,
    ST_H0Q,
    ST_H1A,
    ST_H1B,
    ST_H1Q,
    ST_VA,
    ST_VB,
    ST_VQ,
    ST_VD,
    ST_FIN
  } state_t;

  // size register to last usable index, zero acts as one, large values clamp
  function automatic logic [IDX_W-1:0] size_m1(input logic [CFG_W-1:0] sz);
    logic [IDX_W-1:0] res;
    priority if (sz <= CFG_W'(1)) begin
      res = '0;
    end else if (sz > CFG_W'(STORE_DIM)) begin
      res = IDX_W'(STORE_DIM - 1);
    end else begin
      res = IDX_W'(sz - CFG_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/bub_chan_if.sv
// valid/ready channel interface with a typed payload
// payload types come from bub_pkg at the point of instantiation
`default_nettype none

interface bub_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/bilinear_upscale_byte_frame.sv
// top level of the bilinear upscaler: frame store, sequencer, config registers
// depends on bub_pkg, bub_chan_if, bub_mac and assert_macros.svh
//
// usage:
//   in_chan carries requests: a load writes one source pixel, a read asks
//   for one pixel of the DEST_ROWS x DEST_COLS upscaled frame. out_chan
//   returns exactly one result per request, in order.
//   cfg_we/cfg_index/cfg_wdata write src_rows (index 0) and src_cols (1);
//   write them only while no request is in flight.
// sequencing:
//   a load or a flagged read goes from idle straight to the finish step; an
//   in-range read first runs the position, pixel fetch and lerp steps. no new
//   request is taken until the result leaves the finish step. reads are long due to
//   the single multiply-add unit, which runs fifteen steps per read (three per
//   position, three per linear pass), and the one frame store read port, which fetches four pixels.
// reset:
//   the sequencer returns to idle, the output register empties and both size
//   registers go to 8. the frame store is not cleared; read only loaded pixels.
// stall:
//   a finished result waits in the output register; the next request is
//   taken meanwhile and its result is held until the register frees.
`default_nettype none
`include "assert_macros.svh"

module bilinear_upscale_byte_frame
  import bub_pkg::*;
#(
  parameter int DEST_ROWS = 32,
  parameter int DEST_COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  bub_chan_if.sink             in_chan,
  bub_chan_if.source           out_chan
);

  localparam int FW_C  = $clog2(DEST_COLS);
  localparam int FW_R  = $clog2(DEST_ROWS);
  localparam int FW    = (FW_C > FW_R) ? FW_C : FW_R;
  localparam int K     = LERP_W + FW;
  localparam int MW    = K + 1;
  localparam int PW    = LERP_W + MW;
  localparam int DEN_C = DEST_COLS - 1;
  localparam int DEN_R = DEST_ROWS - 1;

  localparam logic [FW_C-1:0] DEN_C_V = FW_C'(DEN_C);
  localparam logic [FW_R-1:0] DEN_R_V = FW_R'(DEN_R);
  localparam logic [MW-1:0]   MAG_C   = MW'(((2 ** K) + DEN_C - 1) / DEN_C);
  localparam logic [MW-1:0]   MAG_R   = MW'(((2 ** K) + DEN_R - 1) / DEN_R);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] src_rows_r, src_cols_r;
  logic [IDX_W-1:0] rows_m1, cols_m1;

  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [POS_W-1:0] num_r, num_nxt;
  logic [IDX_W-1:0] ic_r, ic_nxt, jr_r, jr_nxt;
  logic [FW_C-1:0]  fc_r, fc_nxt;
  logic [FW_R-1:0]  fr_r, fr_nxt;
  logic [PIX_W-1:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic [PIX_W-1:0] h0_r, h0_nxt, h1_r, h1_nxt;
  logic [PIX_W-1:0] res_value_r, res_value_nxt;
  logic             res_oor_r, res_oor_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_value_r, out_value_nxt;
  logic             out_oor_r, out_oor_nxt;

  logic               mac_en;
  logic [LERP_W-1:0]  mac_a;
  logic [MW-1:0]      mac_b;
  logic [LERP_W-1:0]  mac_add;
  logic [PW-1:0]      mac_prod;
  logic [PIX_W-1:0]   quo;
  logic [POS_W-1:0]   prod_pos;
  logic [LERP_W-1:0]  prod_lerp;

  logic [PIX_W-1:0]       mem [STORE_DIM*STORE_DIM];
  logic [2*IDX_W-1:0]     rd_addr;
  logic [PIX_W-1:0]       mem_q;

  logic in_acc, load_oor, read_oor, mem_we, last_col, last_row;

  assign rows_m1 = size_m1(src_rows_r);
  assign cols_m1 = size_m1(src_cols_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SIZE_RESET;
      src_cols_r <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_ROWS: src_rows_r <= cfg_wdata;
        CFG_SRC_COLS: src_cols_r <= cfg_wdata;
      endcase
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign load_oor      = (in_chan.data.row > rows_m1) || (in_chan.data.col > cols_m1);
  assign read_oor      = (int'(in_chan.data.row) >= DEST_ROWS) ||
                         (int'(in_chan.data.col) >= DEST_COLS);
  assign mem_we        = in_acc && (in_chan.data.req_type == REQ_LOAD) && !load_oor;
  assign last_col      = (int'(col_r) == DEST_COLS - 1);
  assign last_row      = (int'(row_r) == DEST_ROWS - 1);

  assign quo       = mac_prod[K +: PIX_W];
  assign prod_pos  = mac_prod[POS_W-1:0];
  assign prod_lerp = mac_prod[LERP_W-1:0];

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{in_chan.data.row, in_chan.data.col}] <= in_chan.data.pixel;
    end
    mem_q <= mem[rd_addr];
  end

  bub_mac #(
    .A_W   (LERP_W),
    .B_W   (MW),
    .ADD_W (LERP_W)
  ) u_mac (
    .clk  (clk),
    .en   (mac_en),
    .a    (mac_a),
    .b    (mac_b),
    .add  (mac_add),
    .prod (mac_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    num_r       <= num_nxt;
    ic_r        <= ic_nxt;
    jr_r        <= jr_nxt;
    fc_r        <= fc_nxt;
    fr_r        <= fr_nxt;
    p00_r       <= p00_nxt;
    p01_r       <= p01_nxt;
    p10_r       <= p10_nxt;
    p11_r       <= p11_nxt;
    h0_r        <= h0_nxt;
    h1_r        <= h1_nxt;
    res_value_r <= res_value_nxt;
    res_oor_r   <= res_oor_nxt;
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    num_nxt       = num_r;
    ic_nxt        = ic_r;
    jr_nxt        = jr_r;
    fc_nxt        = fc_r;
    fr_nxt        = fr_r;
    p00_nxt       = p00_r;
    p01_nxt       = p01_r;
    p10_nxt       = p10_r;
    p11_nxt       = p11_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    res_value_nxt = res_value_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;
    mac_en        = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    mac_add       = '0;
    rd_addr       = {jr_r, ic_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          row_nxt = in_chan.data.row;
          col_nxt = in_chan.data.col;
          priority if (in_chan.data.req_type == REQ_LOAD) begin
            res_value_nxt = '0;
            res_oor_nxt   = load_oor;
            state_nxt     = ST_FIN;
          end else if (read_oor) begin
            res_value_nxt = '0;
            res_oor_nxt   = 1'b1;
            state_nxt     = ST_FIN;
          end else begin
            res_oor_nxt = 1'b0;
            state_nxt   = ST_CN;
          end
        end
      end
      // column position
      ST_CN: begin
        mac_en    = 1'b1;
        mac_a     = LERP_W'(col_r);
        mac_b     = MW'(cols_m1);
        state_nxt = ST_CQ;
      end
      ST_CQ: begin
        num_nxt   = prod_pos;
        mac_en    = 1'b1;
        mac_a     = LERP_W'(prod_pos);
        mac_b     = MAG_C;
        state_nxt = ST_CR;
      end
      ST_CR: begin
        ic_nxt    = last_col ? cols_m1 : quo[IDX_W-1:0];
        mac_en    = 1'b1;
        mac_a     = LERP_W'(quo[IDX_W-1:0]);
        mac_b     = MW'(DEN_C_V);
        state_nxt = ST_RN;
      end
      // row position
      ST_RN: begin
        fc_nxt    = last_col ? '0 : FW_C'(num_r - prod_pos);
        mac_en    = 1'b1;
        mac_a     = LERP_W'(row_r);
        mac_b     = MW'(rows_m1);
        state_nxt = ST_RQ;
      end
      ST_RQ: begin
        num_nxt   = prod_pos;
        mac_en    = 1'b1;
        mac_a     = LERP_W'(prod_pos);
        mac_b     = MAG_R;
        state_nxt = ST_RR;
      end
      ST_RR: begin
        jr_nxt    = last_row ? rows_m1 : quo[IDX_W-1:0];
        mac_en    = 1'b1;
        mac_a     = LERP_W'(quo[IDX_W-1:0]);
        mac_b     = MW'(DEN_R_V);
        state_nxt = ST_RF;
      end
      ST_RF: begin
        fr_nxt    = last_row ? '0 : FW_R'(num_r - prod_pos);
        rd_addr   = {jr_r, ic_r};
        state_nxt = ST_P1;
      end
      // pixel fetch; neighbors with zero weight copy the near pixel
      ST_P1: begin
        p00_nxt   = mem_q;
        rd_addr   = {jr_r, ic_r + IDX_W'(1)};
        state_nxt = ST_P2;
      end
      ST_P2: begin
        p01_nxt   = (fc_r != '0) ? mem_q : p00_r;
        rd_addr   = {jr_r + IDX_W'(1), ic_r};
        state_nxt = ST_P3;
      end
      ST_P3: begin
        p10_nxt   = (fr_r != '0) ? mem_q : p00_r;
        rd_addr   = {jr_r + IDX_W'(1), ic_r + IDX_W'(1)};
        state_nxt = ST_P4;
      end
      ST_P4: begin
        p11_nxt   = (fr_r == '0) ? p01_r : ((fc_r != '0) ? mem_q : p10_r);
        mac_en    = 1'b1;
        mac_a     = LERP_W'(p00_r);
        mac_b     = MW'(DEN_C_V - fc_r);
        state_nxt = ST_H0B;
      end
      // horizontal passes
      ST_H0B: begin
        mac_en    = 1'b1;
        mac_a     = LERP_W'(p01_r);
        mac_b     = MW'(fc_r);
        mac_add   = prod_lerp;
        state_nxt = ST_H0Q;
      end
      ST_H0Q: begin
        mac_en    = 1'b1;
        mac_a     = prod_lerp;
        mac_b     = MAG_C;
        state_nxt = ST_H1A;
      end
      ST_H1A: begin
        h0_nxt    = quo;
        mac_en    = 1'b1;
        mac_a     = LERP_W'(p10_r);
        mac_b     = MW'(DEN_C_V - fc_r);
        state_nxt = ST_H1B;
      end
      ST_H1B: begin
        mac_en    = 1'b1;
        mac_a     = LERP_W'(p11_r);
        mac_b     = MW'(fc_r);
        mac_add   = prod_lerp;
        state_nxt = ST_H1Q;
      end
      ST_H1Q: begin
        mac_en    = 1'b1;
        mac_a     = prod_lerp;
        mac_b     = MAG_C;
        state_nxt = ST_VA;
      end
      // vertical pass
      ST_VA: begin
        h1_nxt    = quo;
        mac_en    = 1'b1;
        mac_a     = LERP_W'(h0_r);
        mac_b     = MW'(DEN_R_V - fr_r);
        state_nxt = ST_VB;
      end
      ST_VB: begin
        mac_en    = 1'b1;
        mac_a     = LERP_W'(h1_r);
        mac_b     = MW'(fr_r);
        mac_add   = prod_lerp;
        state_nxt = ST_VQ;
      end
      ST_VQ: begin
        mac_en    = 1'b1;
        mac_a     = prod_lerp;
        mac_b     = MAG_R;
        state_nxt = ST_VD;
      end
      ST_VD: begin
        res_value_nxt = quo;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.data.out_value    = out_value_r;
  assign out_chan.data.out_of_range = out_oor_r;

  `ASSERT_NXT(a_read_starts, clk, rst_n, in_acc && (in_chan.data.req_type == REQ_READ) && !read_oor, state_r == ST_CN, "in-range read did not start the sequence")
  `ASSERT_IMP(a_valid_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN, "result appeared outside the finish step")
  `ASSERT_NXT(a_fin_delivers, clk, rst_n, (state_r == ST_FIN) && (!out_valid_r || out_chan.ready), out_valid_r && (state_r == ST_IDLE), "finished result not loaded")
  `ASSERT_IMP(a_frac_bound, clk, rst_n, state_r == ST_P1, (fc_r < DEN_C_V) && (fr_r < DEN_R_V), "position remainder not below divisor")
  `ASSERT_IMP(a_no_write_busy, clk, rst_n, mem_we, state_r == ST_IDLE, "frame write while busy")

endmodule

`default_nettype wire

### hdl/bub_mac.sv
// shared multiply-add unit with registered result
// no dependencies
`default_nettype none

module bub_mac #(
  parameter int A_W   = 16,
  parameter int B_W   = 25,
  parameter int ADD_W = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  input  logic [ADD_W-1:0]   add,
  output logic [A_W+B_W-1:0] prod
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= P_W'(a) * P_W'(b) + P_W'(add);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire
